FILE: design/stl_pkg.sv
package stl_pkg;

  localparam int LINE_CHARS         = 39;
  localparam int HEX_BYTES_PER_LINE = 13;
  localparam int RING_ROWS          = 16;
  localparam int SCROLL_AFTER       = 11;

  localparam int HEX_CHARS = 3 * HEX_BYTES_PER_LINE;
  localparam int MAX_LEN   = ((LINE_CHARS > HEX_CHARS) ? LINE_CHARS : HEX_CHARS) + 2;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(LINE_CHARS);

  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int COUNT_W = 16;

  localparam int FIELD_W = ROW_W + COL_W + BYTE_W + ROW_W + ROW_W + COUNT_W;
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_HEX_MODE        = 1'b0;
  localparam cfg_index_t CFG_CAPTURE_STOPPED = 1'b1;

  typedef struct packed {
    logic accept;
    logic put;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic hex;
    logic rx_lf;
    logic len_full;
    logic flush;
    logic len_nonzero;
    logic put_last;
    logic load_last;
  } status_t;

endpackage

FILE: design/stl_ctrl.sv
module stl_ctrl
  import stl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUT   = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.accept = 1'b1;
          if (!sts.stopped) begin
            state_next = S_PUT;
          end
        end
      end
      S_PUT: begin
        cmd.put = 1'b1;
        if (sts.put_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((!sts.hex && sts.rx_lf) || sts.len_full || (sts.flush && sts.len_nonzero)) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.load_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/stl_dp.sv
module stl_dp
  import stl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  cfg_index_t         cfg_index,
  input  logic               cfg_data,
  input  logic [BYTE_W-1:0]  s_axis_tdata,
  input  logic               s_axis_tlast,
  input  cmd_t               cmd,
  output status_t            sts,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam logic [1:0] PHASE_LAST = 2'd2;

  logic               hex_mode;
  logic               capture_stopped;
  logic [BYTE_W-1:0]  rx_byte;
  logic               flush;
  logic [1:0]         phase;
  logic [LEN_W-1:0]   line_length;
  logic [ROW_W-1:0]   write_row;
  logic [ROW_W-1:0]   window_start;
  logic [ROW_W-1:0]   row_count;
  logic [ROW_W-1:0]   row_count_next;
  logic [ROW_W-1:0]   line_row;
  logic [COUNT_W-1:0] captured_bytes;

  logic [BYTE_W-1:0]  line_buffer [LINE_CHARS];
  logic [BYTE_W-1:0]  rdata;
  logic [ADDR_W-1:0]  load_col;
  logic [ADDR_W-1:0]  load_col_next;

  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [BYTE_W-1:0]  out_char;
  logic [ROW_W-1:0]   out_first;
  logic [ROW_W-1:0]   out_stored;
  logic [COUNT_W-1:0] out_total;

  logic               rx_lf;
  logic               put_last;
  logic               put_we;
  logic [BYTE_W-1:0]  text_char;
  logic [BYTE_W-1:0]  hex_char;
  logic [BYTE_W-1:0]  put_char;
  logic               out_free;
  logic               load;
  logic               load_last_col;
  logic [BYTE_W-1:0]  load_char;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] d;
    d = {4'h0, v};
    if (v > 4'd9) begin
      hex_digit = 8'h41 + d - 8'd10;
    end else begin
      hex_digit = 8'h30 + d;
    end
  endfunction

  // character mapping
  assign rx_lf    = (rx_byte == CHAR_LF);
  assign put_last = !hex_mode || (phase == PHASE_LAST);
  assign put_we   = cmd.put && !(!hex_mode && rx_lf);

  always_comb begin
    if (rx_byte == CHAR_CR) begin
      text_char = CHAR_SPACE;
    end else if ((rx_byte < PRINT_LO || rx_byte > PRINT_HI) && !rx_lf) begin
      text_char = CHAR_STAR;
    end else begin
      text_char = rx_byte;
    end
  end

  always_comb begin
    unique case (phase)
      2'd0:    hex_char = hex_digit(rx_byte[7:4]);
      2'd1:    hex_char = hex_digit(rx_byte[3:0]);
      default: hex_char = CHAR_SPACE;
    endcase
  end

  assign put_char = hex_mode ? hex_char : text_char;

  // emit path
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign load          = cmd.emit && out_free;
  assign load_last_col = (load_col == ADDR_W'(LINE_CHARS - 1));
  assign load_char     = (LEN_W'(load_col) < line_length) ? rdata : CHAR_SPACE;

  always_comb begin
    if (!cmd.emit) begin
      load_col_next = '0;
    end else if (load) begin
      load_col_next = load_last_col ? '0 : load_col + 1'b1;
    end else begin
      load_col_next = load_col;
    end
  end

  assign row_count_next = (row_count < ROW_W'(RING_ROWS - 1)) ? row_count + 1'b1 : row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_mode        <= 1'b0;
      capture_stopped <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEX_MODE:        hex_mode        <= cfg_data;
        CFG_CAPTURE_STOPPED: capture_stopped <= cfg_data;
        default:             hex_mode        <= hex_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rx_byte <= s_axis_tdata;
      flush   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      line_length    <= '0;
      write_row      <= '0;
      window_start   <= '0;
      row_count      <= '0;
      captured_bytes <= '0;
      load_col       <= '0;
    end else begin
      load_col <= load_col_next;
      if (cmd.accept && !capture_stopped) begin
        captured_bytes <= captured_bytes + 1'b1;
      end
      if (cmd.put) begin
        phase <= put_last ? 2'd0 : phase + 2'd1;
      end
      if (put_we) begin
        line_length <= line_length + 1'b1;
      end else if (load && load_last_col) begin
        line_length <= '0;
      end
      if (cmd.commit) begin
        row_count <= row_count_next;
        write_row <= (write_row == ROW_W'(RING_ROWS - 1)) ? '0 : write_row + 1'b1;
        if (row_count_next > ROW_W'(SCROLL_AFTER)) begin
          window_start <= (window_start == ROW_W'(RING_ROWS - 1)) ? '0 : window_start + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      line_row <= write_row;
    end
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (put_we && (line_length < LEN_W'(LINE_CHARS))) begin
      line_buffer[line_length[ADDR_W-1:0]] <= put_char;
    end
    rdata <= line_buffer[load_col_next];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row      <= line_row;
      out_col      <= COL_W'(load_col);
      out_char     <= load_char;
      m_axis_tlast <= load_last_col;
      out_first    <= window_start;
      out_stored   <= row_count;
      out_total    <= captured_bytes;
    end
  end

  assign m_axis_tdata = {{(TDATA_W - FIELD_W){1'b0}}, out_total, out_stored, out_first,
                         out_char, out_col, out_row};

  always_comb begin
    sts             = '0;
    sts.stopped     = capture_stopped;
    sts.hex         = hex_mode;
    sts.rx_lf       = rx_lf;
    sts.len_full    = hex_mode ? (line_length >= LEN_W'(HEX_CHARS))
                               : (line_length >= LEN_W'(LINE_CHARS));
    sts.flush       = flush;
    sts.len_nonzero = (line_length != '0);
    sts.put_last    = put_last;
    sts.load_last   = out_free && load_last_col;
  end

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_col == COL_W'(LINE_CHARS - 1)))
    else $error("last character not at final column");

  a_window_still: assert property (@(posedge clk) disable iff (rst)
    (row_count <= ROW_W'(SCROLL_AFTER)) |-> (window_start == '0))
    else $error("window moved before enough rows");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ((line_length != '0) || (!hex_mode && rx_lf)))
    else $error("empty line committed without line feed");

  a_emit_no_put: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !put_we)
    else $error("line buffer written while emitting");

endmodule

FILE: design/serial_terminal_line_formatter.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata rx_byte, tlast chunk_end
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata line/char fields, tlast last_char
// cfg       in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// text byte steps: accept, write, decide; hex byte steps: accept, three buffer writes, decide
// a committed line then sends 39 characters, one character per cycle from the buffer read port,
// stalling while m_axis_tready is low
// s_axis_tready is high only between requests; cfg_ready is always high
// after reset capture is stopped and text mode is selected
module serial_terminal_line_formatter
  import stl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_index_t         cfg_index,
  input  logic               cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,   // rx_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // line_row, column, shown_char, first_visible_row, stored_rows, byte_total, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  stl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  stl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
